### rtl/bfi_pkg.sv
// Package with shared types and constants of the interpreter step block.
`default_nettype none
package bfi_pkg;
  typedef enum logic [1:0] {
    OP_LOAD_PROG  = 2'd0,
    OP_LOAD_INPUT = 2'd1,
    OP_RUN        = 2'd2,
    OP_TICK       = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CHAR      = 3'd0,
    ST_HALT_OK   = 3'd1,
    ST_UNBALANCE = 3'd2,
    ST_NO_INPUT  = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_OUT
  } fsm_e;

  localparam logic [7:0] CmdInc   = 8'h2B;
  localparam logic [7:0] CmdDec   = 8'h2D;
  localparam logic [7:0] CmdRight = 8'h3E;
  localparam logic [7:0] CmdLeft  = 8'h3C;
  localparam logic [7:0] CmdOut   = 8'h2E;
  localparam logic [7:0] CmdIn    = 8'h2C;
  localparam logic [7:0] CmdOpen  = 8'h5B;
  localparam logic [7:0] CmdClose = 8'h5D;
endpackage
`default_nettype wire

### rtl/bfi_in_if.sv
// Handshake interface for the input item channel.
`default_nettype none
interface bfi_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data;
  modport source (output valid, output op, output data, input ready);
  modport sink (input valid, input op, input data, output ready);
endinterface
`default_nettype wire

### rtl/bfi_out_if.sv
// Handshake interface for the result item channel.
`default_nettype none
interface bfi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [2:0] status;
  modport source (output valid, output out_char, output status, input ready);
  modport sink (input valid, input out_char, input status, output ready);
endinterface
`default_nettype wire

### rtl/bfi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module bfi_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/bf_interpreter_step.sv
// Top level of the interpreter step block: control sequencer and its memories.
//
//  channel  | dir | beat fields
//  in_ch    | in  | op[1:0], data[7:0]
//  out_ch   | out | out_char[7:0], status[2:0]
//  cfg      | in  | precalc_mode (cfg_we_i, cfg_wdata_i)
//
// Loads and run beats are handled in S_IDLE. A tick goes through S_READ,
// where the program, tape, input and loop stack memories are read, and
// S_EXEC, where the command is executed and the tape written back. A result
// is held in the output register; the next beat is taken once it is gone.
// After reset a clearing pass writes zero to each tape cell; no beat is
// accepted during it.
`default_nettype none
module bf_interpreter_step
  import bfi_pkg::*;
#(
  parameter int PROG_DEPTH  = 4096,
  parameter int TAPE_DEPTH  = 1024,
  parameter int INPUT_DEPTH = 256,
  parameter int STACK_DEPTH = 32
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  bfi_in_if.sink   in_ch,
  bfi_out_if.source out_ch,
  input wire logic cfg_we_i,
  input wire logic cfg_wdata_i
);
  localparam int PAW = $clog2(PROG_DEPTH);
  localparam int TAW = $clog2(TAPE_DEPTH);
  localparam int IAW = $clog2(INPUT_DEPTH) > 0 ? $clog2(INPUT_DEPTH) : 1;
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int PLW = PAW + 1;
  localparam int ILW = $clog2(INPUT_DEPTH + 1);
  localparam int SCW = SAW + 1;

  fsm_e            state_q, state_d;
  logic            precalc_q;
  logic [PLW-1:0]  plen_q, plen_d, ip_q, ip_d;
  logic [ILW-1:0]  ilen_q, ilen_d, iidx_q, iidx_d;
  logic [TAW-1:0]  cp_q, cp_d;
  logic [SCW-1:0]  sc_q, sc_d;
  logic [PLW-1:0]  skip_q, skip_d;
  logic            halted_q, halted_d;
  logic            clr_busy_q;
  logic [TAW:0]    clr_cnt_q;
  logic [7:0]      char_q, char_d;
  logic [2:0]      stat_q, stat_d;

  // Memory ports.
  logic            p_we, i_we, t_we, s_we;
  logic [PAW-1:0]  p_waddr, p_raddr;
  logic [IAW-1:0]  i_waddr, i_raddr;
  logic [TAW-1:0]  t_waddr;
  logic [SAW-1:0]  s_waddr, s_raddr;
  logic [7:0]      p_rdata, i_rdata, t_rdata, t_wdata;
  logic [PAW-1:0]  s_rdata;

  bfi_ram #(.Width(8), .Depth(PROG_DEPTH)) u_prog (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(in_ch.data),
    .raddr_i(p_raddr), .rdata_o(p_rdata));
  bfi_ram #(.Width(8), .Depth(2 ** IAW)) u_input (
    .clk_i, .we_i(i_we), .waddr_i(i_waddr), .wdata_i(in_ch.data),
    .raddr_i(i_raddr), .rdata_o(i_rdata));
  bfi_ram #(.Width(8), .Depth(TAPE_DEPTH)) u_tape (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .raddr_i(cp_q), .rdata_o(t_rdata));
  bfi_ram #(.Width(PAW), .Depth(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(ip_q[PAW-1:0]),
    .raddr_i(s_raddr), .rdata_o(s_rdata));

  logic accept;
  assign in_ch.ready   = (state_q == S_IDLE) && !clr_busy_q;
  assign accept        = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = (state_q == S_OUT);
  assign out_ch.out_char = char_q;
  assign out_ch.status   = stat_q;

  assign p_waddr = plen_q[PAW-1:0];
  assign p_raddr = ip_q[PAW-1:0];
  assign i_waddr = ilen_q[IAW-1:0];
  assign i_raddr = iidx_q[IAW-1:0];
  assign s_raddr = sc_q[SAW-1:0] - SAW'(1);
  assign s_waddr = sc_q[SAW-1:0];
  assign p_we = accept && (in_ch.op == OP_LOAD_PROG) && (plen_q < PLW'(PROG_DEPTH));
  assign i_we = accept && (in_ch.op == OP_LOAD_INPUT) && (ilen_q < ILW'(INPUT_DEPTH));

  // Sequencer: next state, register updates and tape write-back.
  always_comb begin
    state_d = state_q;
    plen_d = plen_q; ilen_d = ilen_q; iidx_d = iidx_q; ip_d = ip_q;
    cp_d = cp_q; sc_d = sc_q; skip_d = skip_q; halted_d = halted_q;
    char_d = char_q; stat_d = stat_q;
    t_we = 1'b0; t_waddr = cp_q; t_wdata = 8'd0; s_we = 1'b0;
    if (clr_busy_q) begin
      t_we = 1'b1;
      t_waddr = clr_cnt_q[TAW-1:0];
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.op)
            OP_LOAD_PROG:  if (p_we) plen_d = plen_q + PLW'(1);
            OP_LOAD_INPUT: if (i_we) ilen_d = ilen_q + ILW'(1);
            OP_RUN: begin
              ip_d = '0; cp_d = '0; iidx_d = '0; sc_d = '0; skip_d = '0;
              halted_d = 1'b0;
            end
            default: begin
              if (!halted_q) begin
                if (ip_q >= plen_q) begin
                  halted_d = 1'b1; char_d = 8'd0; stat_d = ST_HALT_OK;
                  state_d = S_OUT;
                end else begin
                  state_d = S_READ;
                end
              end
            end
          endcase
        end
      end
      S_READ: state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_IDLE;
        ip_d = ip_q + PLW'(1);
        if (skip_q != '0) begin
          if (p_rdata == CmdOpen) skip_d = skip_q + PLW'(1);
          else if (p_rdata == CmdClose) skip_d = skip_q - PLW'(1);
        end else begin
          case (p_rdata)
            CmdInc: begin t_we = 1'b1; t_wdata = t_rdata + 8'd1; end
            CmdDec: begin t_we = 1'b1; t_wdata = t_rdata - 8'd1; end
            CmdRight: cp_d = (cp_q == TAW'(TAPE_DEPTH - 1)) ? '0 : cp_q + TAW'(1);
            CmdLeft:  cp_d = (cp_q == '0) ? TAW'(TAPE_DEPTH - 1) : cp_q - TAW'(1);
            CmdOut: begin
              char_d = t_rdata; stat_d = ST_CHAR; state_d = S_OUT;
            end
            CmdIn: begin
              if (precalc_q || iidx_q >= ilen_q) begin
                ip_d = ip_q; halted_d = 1'b1; char_d = 8'd0;
                stat_d = precalc_q ? ST_HALT_OK : ST_NO_INPUT;
                state_d = S_OUT;
              end else begin
                t_we = 1'b1; t_wdata = i_rdata; iidx_d = iidx_q + ILW'(1);
              end
            end
            CmdOpen: begin
              if (t_rdata == 8'd0) begin
                skip_d = PLW'(1);
              end else if (sc_q >= SCW'(STACK_DEPTH)) begin
                ip_d = ip_q; halted_d = 1'b1; char_d = 8'd0;
                stat_d = ST_OVERFLOW; state_d = S_OUT;
              end else begin
                s_we = 1'b1; sc_d = sc_q + SCW'(1);
              end
            end
            CmdClose: begin
              if (sc_q == '0) begin
                ip_d = ip_q; halted_d = 1'b1; char_d = 8'd0;
                stat_d = ST_UNBALANCE; state_d = S_OUT;
              end else if (t_rdata != 8'd0) begin
                ip_d = {1'b0, s_rdata} + PLW'(1);
              end else begin
                sc_d = sc_q - SCW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      S_OUT: if (out_ch.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; precalc_q <= 1'b0;
      plen_q <= '0; ilen_q <= '0; iidx_q <= '0; ip_q <= '0; cp_q <= '0;
      sc_q <= '0; skip_q <= '0; halted_q <= 1'b1;
      clr_busy_q <= 1'b1; clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) precalc_q <= cfg_wdata_i;
      plen_q <= plen_d; ilen_q <= ilen_d; iidx_q <= iidx_d; ip_q <= ip_d;
      cp_q <= cp_d; sc_q <= sc_d; skip_q <= skip_d; halted_q <= halted_d;
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + (TAW + 1)'(1);
        if (clr_cnt_q == (TAW + 1)'(TAPE_DEPTH - 1)) clr_busy_q <= 1'b0;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    stat_q <= stat_d;
  end

`ifndef SYNTHESIS
  // No beat is taken during the tape clearing pass.
  a_clr_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_ch.ready) else $error("beat during clear");
  // The loop stack never exceeds its depth.
  a_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_q <= SCW'(STACK_DEPTH)) else $error("stack count overflow");
  // A read cycle is always followed by execution.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> state_q == S_EXEC) else $error("sequence broken");
`endif
endmodule
`default_nettype wire
